// ===== hdl/wavhp_pkg.sv =====
// Package for the WAV header parser: payload structs, chunk tags, status codes
// and the command and status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
package wavhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_CUE  = 32'h2065_7563;
    localparam logic [31:0] TAG_LIST = 32'h5453_494c;
    localparam logic [31:0] TAG_MARK = 32'h6b72_616d;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_RIFF  = 3'd1;
    localparam logic [2:0] ST_NO_FMT   = 3'd2;
    localparam logic [2:0] ST_NOT_PCM  = 3'd3;
    localparam logic [2:0] ST_NO_DATA  = 3'd4;
    localparam logic [2:0] ST_ZERO_W   = 3'd5;

    localparam logic [0:0] REG_IGNORE_CUE = 1'd0;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        audio_format;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [12:0]        bytes_per_sample;
        logic signed [31:0] loop_start;
        logic signed [31:0] sample_count;
        logic [31:0]        data_offset;
    } out_beat_t;

    // Controller to datapath.
    typedef struct packed {
        logic step;      // take one byte
        logic clear;     // return the parse to its reset state
        logic div_start; // load the divider
        logic div_step;  // one quotient bit
    } wavhp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_div;  // result needs data_length / width
    } wavhp_sts_t;

endpackage

// ===== hdl/wav_header_parser_unit.sv =====
// WAV header parser, top level: APB register, controller and datapath.
// Depends on wavhp_pkg, wavhp_ctrl and wavhp_datapath.
//
// Usage: feed the file one byte per beat on in_valid/in_ready with last_byte
// set on the final byte. Bytes before the last are taken one per cycle.
// After the last byte the parser checks the header and, for a good PCM file,
// divides the data length by the sample width in a bit-serial divider; one
// result beat then appears on out_valid/out_ready. Bytes of the next file are
// taken again once the controller has passed its clear state (S_DONE) after
// the result is formed, while that beat may still wait. If the receiver
// stalls, the following result waits in the datapath, and in_ready stays
// low, until the waiting beat is taken. Reset clears the parse and the
// ignore_cue_chunk register (address 0, bit 0), which is sampled when the
// result is formed.
`timescale 1ns / 1ps
module wav_header_parser_unit #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wavhp_pkg::in_beat_t  in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wavhp_pkg::out_beat_t out_beat,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import wavhp_pkg::*;

    logic        ign_reg;
    wavhp_cmd_t  cmd;
    wavhp_sts_t  sts;
    out_beat_t   result;
    in_beat_t    beat;

    assign beat = in_beat;
    assign pready = 1'b1;
    assign prdata = {31'd0, ign_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ign_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 2'(REG_IGNORE_CUE * 4))
            ign_reg <= pwdata[0];
    end

    // Last byte is stepped in its own cycle, then the divider loads.
    logic        last_reg;
    wavhp_cmd_t  dcmd;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= 1'b0;
        else
            last_reg <= cmd.div_start;
    end
    always_comb
    begin
        dcmd = cmd;
        dcmd.div_start = last_reg;
        dcmd.step = cmd.step || cmd.div_start;
    end

    wavhp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .last_byte(beat.last_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .result(result), .out_beat(out_beat), .cmd(cmd), .sts(sts)
    );

    wavhp_datapath #(.OFFSET_BITS(OFFSET_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(dcmd), .sts(sts),
        .file_byte(beat.file_byte),
        .ignore_cue(ign_reg), .result(result)
    );

endmodule

// ===== hdl/wavhp_datapath.sv =====
// Datapath of the WAV header parser: chunk walker, field capture, result
// assembly and a bit-serial divider. Depends on wavhp_pkg.
`timescale 1ns / 1ps
module wavhp_datapath #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wavhp_pkg::wavhp_cmd_t cmd,
    output wavhp_pkg::wavhp_sts_t sts,
    input  logic [7:0]            file_byte,
    input  logic                  ignore_cue,
    output wavhp_pkg::out_beat_t  result
);
    import wavhp_pkg::*;

    localparam int PW = OFFSET_BITS + 1; // holds the limit 2^OFFSET_BITS
    localparam logic [PW-1:0] POS_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

    typedef enum logic [1:0] {PH_TOP, PH_TYPE, PH_INNER, PH_STOP} phase_t;

    logic [PW-1:0] pos_reg, next_pos_reg, base_reg;
    logic [PW-1:0] fmt_base_reg, cue_base_reg, list_base_reg, dbody_reg;
    logic [31:0]   id_reg, len_reg;
    phase_t        phase_reg;
    logic [3:0]    hidx_reg; // 12 means idle
    logic          f_riff_reg, f_fmt_reg, f_cue_reg, f_list_reg, f_data_reg;
    logic [15:0]   fmt_w_reg, chn_w_reg, bits_w_reg;
    logic [31:0]   rate_w_reg, cue_w_reg, mlen_reg, mtag_reg, dlen_reg;

    // Divider.
    logic [31:0] q_reg, r_reg;

    localparam logic [3:0] IDX_IDLE = 4'd12;

    function automatic logic [31:0] grab(logic [31:0] w, logic [PW-1:0] p,
                                         logic [PW-1:0] b, int lo, int n, logic [7:0] d);
        logic [PW+1:0] off;
        off = {2'b00, p} - {2'b00, b} - (PW+2)'(lo);
        if (p >= b && {2'b00, p} >= {2'b00, b} + (PW+2)'(lo) && off < (PW+2)'(n))
            w[off[1:0]*8 +: 8] = d;
        return w;
    endfunction

    logic [12:0] bps;
    assign bps = bits_w_reg[15:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; next_pos_reg <= '0; base_reg <= '0;
            id_reg <= '0; len_reg <= '0; phase_reg <= PH_TOP; hidx_reg <= IDX_IDLE;
            f_riff_reg <= 1'b0; f_fmt_reg <= 1'b0; f_cue_reg <= 1'b0;
            f_list_reg <= 1'b0; f_data_reg <= 1'b0;
            fmt_w_reg <= '0; chn_w_reg <= '0; bits_w_reg <= '0; rate_w_reg <= '0;
            cue_w_reg <= '0; mlen_reg <= '0; mtag_reg <= '0; dlen_reg <= '0;
            dbody_reg <= '0; fmt_base_reg <= '0; cue_base_reg <= '0; list_base_reg <= '0;
            q_reg <= '0; r_reg <= '0;
        end
        else if (cmd.clear)
        begin
            pos_reg <= '0; next_pos_reg <= '0; base_reg <= '0;
            id_reg <= '0; len_reg <= '0; phase_reg <= PH_TOP; hidx_reg <= IDX_IDLE;
            f_riff_reg <= 1'b0; f_fmt_reg <= 1'b0; f_cue_reg <= 1'b0;
            f_list_reg <= 1'b0; f_data_reg <= 1'b0;
            fmt_w_reg <= '0; chn_w_reg <= '0; bits_w_reg <= '0; rate_w_reg <= '0;
            cue_w_reg <= '0; mlen_reg <= '0; mtag_reg <= '0; dlen_reg <= '0;
            dbody_reg <= '0; fmt_base_reg <= '0; cue_base_reg <= '0; list_base_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            q_reg <= dlen_reg; r_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            logic [32:0] tr;
            tr = {r_reg, q_reg[31]};
            if (tr >= {20'd0, bps})
            begin
                r_reg <= 32'(tr - {20'd0, bps});
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= tr[31:0];
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
        else if (cmd.step && pos_reg < POS_LIMIT)
        begin
            logic [3:0]  hi;
            logic [31:0] id, ln;
            logic [PW-1:0] bs;
            hi = hidx_reg; id = id_reg; ln = len_reg; bs = base_reg;
            pos_reg <= pos_reg + PW'(1);
            if ((phase_reg == PH_TOP || phase_reg == PH_INNER) && hi == IDX_IDLE
                && pos_reg == next_pos_reg)
            begin
                hi = 4'd0; bs = pos_reg; id = '0; ln = '0;
            end
            base_reg <= bs;
            if (hi < 4'd4)
            begin
                id[hi[1:0]*8 +: 8] = file_byte;
                hi = hi + 4'd1;
            end
            else if (hi < 4'd8)
            begin
                ln[hi[1:0]*8 +: 8] = file_byte;
                if (hi == 4'd7)
                begin
                    logic [PW+1:0] sw;
                    logic [PW-1:0] st;
                    sw = {2'b00, bs} + (PW+2)'(8) + (PW+2)'(({1'b0, ln} + 33'd1) & ~33'd1);
                    st = (sw > {2'b00, POS_LIMIT}) ? POS_LIMIT : sw[PW-1:0];
                    hi = IDX_IDLE;
                    if (ln[31])
                        phase_reg <= PH_STOP;
                    else if (phase_reg == PH_TOP)
                    begin
                        if (id == TAG_RIFF)
                        begin
                            phase_reg <= PH_TYPE; hi = 4'd8; id = '0;
                        end
                        else
                            next_pos_reg <= st;
                    end
                    else
                    begin
                        next_pos_reg <= st;
                        if (id == TAG_FMT && !f_fmt_reg)
                        begin
                            f_fmt_reg <= 1'b1; fmt_base_reg <= bs;
                        end
                        else if (id == TAG_CUE && !f_cue_reg)
                        begin
                            f_cue_reg <= 1'b1; cue_base_reg <= bs;
                        end
                        else if (id == TAG_LIST && f_cue_reg && !f_list_reg)
                        begin
                            f_list_reg <= 1'b1; list_base_reg <= bs;
                        end
                        else if (id == TAG_DATA && !f_data_reg)
                        begin
                            f_data_reg <= 1'b1; dlen_reg <= ln;
                            dbody_reg <= bs + PW'(8);
                        end
                    end
                end
                else
                    hi = hi + 4'd1;
            end
            else if (hi < 4'd12 && phase_reg == PH_TYPE)
            begin
                id[hi[1:0]*8 +: 8] = file_byte;
                if (hi == 4'd11)
                begin
                    hi = IDX_IDLE;
                    if (id == TAG_WAVE)
                    begin
                        f_riff_reg <= 1'b1; phase_reg <= PH_INNER;
                        next_pos_reg <= bs + PW'(12);
                    end
                    else
                        phase_reg <= PH_STOP;
                end
                else
                    hi = hi + 4'd1;
            end
            hidx_reg <= hi; id_reg <= id; len_reg <= ln;
            // Capture uses flags from before this byte, as bases set now lie behind.
            if (f_fmt_reg)
            begin
                fmt_w_reg  <= 16'(grab({16'd0, fmt_w_reg}, pos_reg, fmt_base_reg, 8, 2, file_byte));
                chn_w_reg  <= 16'(grab({16'd0, chn_w_reg}, pos_reg, fmt_base_reg, 10, 2, file_byte));
                rate_w_reg <= grab(rate_w_reg, pos_reg, fmt_base_reg, 12, 4, file_byte);
                bits_w_reg <= 16'(grab({16'd0, bits_w_reg}, pos_reg, fmt_base_reg, 22, 2, file_byte));
            end
            if (f_cue_reg)
                cue_w_reg <= grab(cue_w_reg, pos_reg, cue_base_reg, 32, 4, file_byte);
            if (f_list_reg)
            begin
                mlen_reg <= grab(mlen_reg, pos_reg, list_base_reg, 24, 4, file_byte);
                mtag_reg <= grab(mtag_reg, pos_reg, list_base_reg, 28, 4, file_byte);
            end
        end
    end

    assign sts.need_div = f_riff_reg && f_fmt_reg && fmt_w_reg == 16'd1 && f_data_reg
                          && bps != 13'd0;

    always_comb
    begin
        logic [31:0] loop, samp;
        result = '0;
        loop = 32'hFFFF_FFFF;
        samp = '0;
        if (!ignore_cue && f_cue_reg)
        begin
            loop = cue_w_reg;
            if (f_list_reg && mtag_reg == TAG_MARK)
                samp = loop + mlen_reg;
        end
        if (!f_riff_reg)
            result.status = ST_NO_RIFF;
        else if (!f_fmt_reg)
            result.status = ST_NO_FMT;
        else
        begin
            result.audio_format = fmt_w_reg;
            result.channel_count = chn_w_reg;
            result.sample_rate = rate_w_reg;
            result.bytes_per_sample = bps;
            if (fmt_w_reg != 16'd1)
                result.status = ST_NOT_PCM;
            else
            begin
                result.loop_start = loop;
                if (!f_data_reg)
                begin
                    result.status = ST_NO_DATA;
                    result.sample_count = samp;
                end
                else
                begin
                    result.data_offset = 32'(dbody_reg);
                    if (bps == 13'd0)
                        result.status = ST_ZERO_W;
                    else
                    begin
                        result.status = ST_OK;
                        result.sample_count = q_reg;
                    end
                end
            end
        end
    end

endmodule

// ===== hdl/wavhp_ctrl.sv =====
// Controller of the WAV header parser: accepts bytes, runs the divider after
// the last byte and holds the result beat. Depends on wavhp_pkg.
`timescale 1ns / 1ps
module wavhp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  last_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  wavhp_pkg::out_beat_t  result,
    output wavhp_pkg::out_beat_t  out_beat,
    output wavhp_pkg::wavhp_cmd_t cmd,
    input  wavhp_pkg::wavhp_sts_t sts
);
    import wavhp_pkg::*;

    typedef enum logic [1:0] {S_RUN, S_DIV, S_DONE} state_t;

    state_t      state_reg;
    logic [5:0]  cnt_reg;
    logic        ovalid_reg;
    out_beat_t   obeat_reg;
    logic        in_acc;
    logic        div_done;
    logic        emit;

    assign in_ready  = (state_reg == S_RUN);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_beat  = obeat_reg;
    assign div_done  = (state_reg == S_DIV)
                       && (cnt_reg == 6'd0 || (!sts.need_div && cnt_reg < 6'd32));
    // A finished result waits here while the previous beat is still unaccepted.
    assign emit      = div_done && (!ovalid_reg || out_ready);

    always_comb
    begin
        cmd = '0;
        cmd.step = in_acc && !last_byte;
        cmd.div_start = in_acc && last_byte;
        cmd.div_step = (state_reg == S_DIV) && cnt_reg != 6'd0;
        cmd.clear = (state_reg == S_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            cnt_reg <= '0;
            ovalid_reg <= 1'b0;
            obeat_reg <= '0;
        end
        else
        begin
            if (emit)
            begin
                obeat_reg <= result;
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_RUN:
                begin
                    // The last byte is stepped first, in the cycle before the divider loads.
                    if (in_acc && last_byte)
                    begin
                        state_reg <= S_DIV;
                        cnt_reg <= 6'd33;
                    end
                end
                S_DIV:
                begin
                    if (emit)
                        state_reg <= S_DONE;
                    else if (!div_done)
                        cnt_reg <= cnt_reg - 6'd1;
                end
                S_DONE:
                    state_reg <= S_RUN;
                default:
                    state_reg <= S_RUN;
            endcase
        end
    end

endmodule

// ===== test/wavhp_checker.sv =====
// Checker for the WAV header parser: follows the byte channel and the register
// port, predicts each result beat and compares it with what the block sends.
// Depends on wavhp_pkg.
`timescale 1ns / 1ps
module wavhp_checker
    import wavhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_beat_t   in_beat,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_beat_t  out_beat,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic       pready,
    output int         errors,
    output int         pending
);

    localparam logic [63:0] POS_LIMIT = 64'h1_0000_0000;
    localparam int HDR_IDLE = 12;

    typedef enum logic [1:0] {WALK_TOP, WALK_TYPE, WALK_INNER, WALK_STOP} walk_t;

    out_beat_t   header_results[$];
    logic [63:0] pos, next_hdr, hdr_base, fmt_at, cue_at, list_at, body_at;
    logic [31:0] id_acc, len_acc, rate_w, cue_w, mark_len, mark_w, data_len;
    logic [15:0] fmt_w, chan_w, bits_w;
    walk_t       walk;
    int          hdr_idx;
    bit          got_riff, got_fmt, got_cue, got_list, got_data;
    bit          ignore_cue;

    task automatic clear_walk();
        pos = 0; next_hdr = 0; hdr_base = 0; fmt_at = 0; cue_at = 0; list_at = 0;
        body_at = 0; id_acc = 0; len_acc = 0; rate_w = 0; cue_w = 0; mark_len = 0;
        mark_w = 0; data_len = 0; fmt_w = 0; chan_w = 0; bits_w = 0;
        walk = WALK_TOP; hdr_idx = HDR_IDLE;
        got_riff = 0; got_fmt = 0; got_cue = 0; got_list = 0; got_data = 0;
    endtask

    // Drops byte b into word when p falls in [base+lo, base+lo+n).
    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [63:0] p,
                                             input logic [63:0] base, input int lo,
                                             input int n, input logic [7:0] b);
        logic [63:0] start;
        int sh;
        start = base + lo;
        if (p >= start && p < start + n) begin
            sh = int'(p - start) * 8;
            word = (word & ~(32'hFF << sh)) | ({24'b0, b} << sh);
        end
        return word;
    endfunction

    function automatic logic [63:0] skip_to();
        logic [63:0] t;
        t = hdr_base + 8 + (({32'b0, len_acc} + 64'd1) & ~64'd1);
        return (t > POS_LIMIT) ? POS_LIMIT : t;
    endfunction

    task automatic end_header();
        hdr_idx = HDR_IDLE;
        if (len_acc[31]) begin
            walk = WALK_STOP;
        end
        else if (walk == WALK_TOP) begin
            if (id_acc == TAG_RIFF) begin
                walk = WALK_TYPE;
                hdr_idx = 8;
                id_acc = 0;
            end
            else begin
                next_hdr = skip_to();
            end
        end
        else begin
            next_hdr = skip_to();
            if (id_acc == TAG_FMT && !got_fmt) begin
                got_fmt = 1;
                fmt_at = hdr_base;
            end
            else if (id_acc == TAG_CUE && !got_cue) begin
                got_cue = 1;
                cue_at = hdr_base;
            end
            else if (id_acc == TAG_LIST && got_cue && !got_list) begin
                got_list = 1;
                list_at = hdr_base;
            end
            else if (id_acc == TAG_DATA && !got_data) begin
                got_data = 1;
                data_len = len_acc;
                body_at = hdr_base + 8;
            end
        end
    endtask

    task automatic walk_byte(input logic [7:0] b);
        if ((walk == WALK_TOP || walk == WALK_INNER) && hdr_idx == HDR_IDLE
                && pos == next_hdr) begin
            hdr_idx = 0;
            hdr_base = pos;
            id_acc = 0;
            len_acc = 0;
        end
        if (hdr_idx < 4) begin
            id_acc = id_acc | ({24'b0, b} << (8 * hdr_idx));
            hdr_idx++;
        end
        else if (hdr_idx < 8) begin
            len_acc = len_acc | ({24'b0, b} << (8 * (hdr_idx - 4)));
            if (hdr_idx == 7)
                end_header();
            else
                hdr_idx++;
        end
        else if (hdr_idx < HDR_IDLE && walk == WALK_TYPE) begin
            id_acc = id_acc | ({24'b0, b} << (8 * (hdr_idx - 8)));
            if (hdr_idx == 11) begin
                hdr_idx = HDR_IDLE;
                if (id_acc == TAG_WAVE) begin
                    got_riff = 1;
                    walk = WALK_INNER;
                    next_hdr = hdr_base + 12;
                end
                else begin
                    walk = WALK_STOP;
                end
            end
            else begin
                hdr_idx++;
            end
        end
    endtask

    task automatic capture_fields(input logic [7:0] b);
        if (got_fmt) begin
            fmt_w  = 16'(put_byte({16'b0, fmt_w}, pos, fmt_at, 8, 2, b));
            chan_w = 16'(put_byte({16'b0, chan_w}, pos, fmt_at, 10, 2, b));
            rate_w = put_byte(rate_w, pos, fmt_at, 12, 4, b);
            bits_w = 16'(put_byte({16'b0, bits_w}, pos, fmt_at, 22, 2, b));
        end
        if (got_cue)
            cue_w = put_byte(cue_w, pos, cue_at, 32, 4, b);
        if (got_list) begin
            mark_len = put_byte(mark_len, pos, list_at, 24, 4, b);
            mark_w   = put_byte(mark_w, pos, list_at, 28, 4, b);
        end
    endtask

    // Takes one accepted byte; on the last byte of a file the header result
    // is formed and queued.
    task automatic take_byte(input logic [7:0] b, input logic fin);
        out_beat_t r;
        logic [31:0] width;
        if (pos < POS_LIMIT) begin
            walk_byte(b);
            capture_fields(b);
            pos = pos + 1;
        end
        if (fin) begin
            r = '0;
            if (!got_riff) begin
                r.status = ST_NO_RIFF;
            end
            else if (!got_fmt) begin
                r.status = ST_NO_FMT;
            end
            else begin
                width = {16'b0, bits_w} / 8;
                r.audio_format = fmt_w;
                r.channel_count = chan_w;
                r.sample_rate = rate_w;
                r.bytes_per_sample = width[12:0];
                if (fmt_w != 16'd1) begin
                    r.status = ST_NOT_PCM;
                end
                else begin
                    if (ignore_cue || !got_cue) begin
                        r.loop_start = -1;
                    end
                    else begin
                        r.loop_start = cue_w;
                        if (got_list && mark_w == TAG_MARK)
                            r.sample_count = cue_w + mark_len;
                    end
                    if (!got_data) begin
                        r.status = ST_NO_DATA;
                    end
                    else begin
                        r.data_offset = body_at[31:0];
                        if (width == 0) begin
                            r.status = ST_ZERO_W;
                            r.sample_count = 0;
                        end
                        else begin
                            r.status = ST_OK;
                            r.sample_count = data_len / width;
                        end
                    end
                end
            end
            header_results.push_back(r);
            clear_walk();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n) begin
            clear_walk();
            header_results.delete();
            ignore_cue <= 1'b0;
            errors <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == 2'(REG_IGNORE_CUE * 4))
                ignore_cue <= pwdata[0];
            if (in_valid && in_ready)
                take_byte(in_beat.file_byte, in_beat.last_byte);
            if (out_valid && out_ready) begin
                if (header_results.size() == 0) begin
                    $display("%0t: result beat with none expected, got %p", $time, out_beat);
                    errors++;
                end
                else begin
                    want = header_results.pop_front();
                    check_field("status", 32'(want.status), 32'(out_beat.status));
                    check_field("audio_format", 32'(want.audio_format),
                                32'(out_beat.audio_format));
                    check_field("channel_count", 32'(want.channel_count),
                                32'(out_beat.channel_count));
                    check_field("sample_rate", want.sample_rate, out_beat.sample_rate);
                    check_field("bytes_per_sample", 32'(want.bytes_per_sample),
                                32'(out_beat.bytes_per_sample));
                    check_field("loop_start", want.loop_start, out_beat.loop_start);
                    check_field("sample_count", want.sample_count, out_beat.sample_count);
                    check_field("data_offset", want.data_offset, out_beat.data_offset);
                end
            end
        end
        pending = header_results.size();
    end

endmodule

// ===== test/testbench.sv =====
// Top of the WAV header parser testbench: clock, reset, file stimulus, register
// writes and the verdict. Depends on wavhp_pkg, wav_header_parser_unit and
// wavhp_checker.
`timescale 1ns / 1ps
module testbench;
    import wavhp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 60;

    typedef enum {CK_FMT, CK_CUE, CK_LIST, CK_DATA, CK_JUNK, CK_NEG} chunk_kind_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_beat_t   in_beat = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_beat_t  out_beat;
    logic       psel = 1'b0;
    logic       penable = 1'b0;
    logic       pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic       pready;
    int         errors;
    int         pending;
    int         cycles = 0;
    int         burst_left = 0;
    int         stall_mode = 0;
    int         bytes_sent = 0;
    logic [7:0] wav_bytes[$];

    wav_header_parser_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
        .out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wavhp_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
        .out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver switches between always ready, coin flips and long stalls.
    always @(posedge clk)
    begin
        if (cycles % 97 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic put8(input logic [7:0] v);
        wav_bytes.push_back(v);
    endtask

    task automatic put16(input logic [15:0] v);
        put8(v[7:0]);
        put8(v[15:8]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[15:0]);
        put16(v[31:16]);
    endtask

    task automatic put_noise(input int n);
        repeat (n) put8(8'($urandom_range(0, 255)));
    endtask

    task automatic put_header(input logic [31:0] id, input logic [31:0] len);
        put32(id);
        put32(len);
    endtask

    // Pads a chunk body of n bytes up to even length.
    task automatic put_pad(input int n);
        if (n % 2 != 0)
            put8(8'($urandom_range(0, 255)));
    endtask

    task automatic put_chunk(input chunk_kind_t kind, input logic [15:0] fmt_tag,
                             input logic [15:0] bits, input bit marked,
                             input logic [31:0] dlen, input int dbody);
        int extra;
        extra = $urandom_range(0, 3);
        case (kind)
            CK_FMT: begin
                put_header(TAG_FMT, 32'(16 + extra));
                put16(fmt_tag);
                put16(16'($urandom));
                put32($urandom);
                put32($urandom);
                put16(16'($urandom));
                put16(bits);
                put_noise(extra);
                put_pad(extra);
            end
            CK_CUE: begin
                put_header(TAG_CUE, 32'(28 + extra));
                put_noise(24);
                put32($urandom);
                put_noise(extra);
                put_pad(extra);
            end
            CK_LIST: begin
                put_header(TAG_LIST, 32'(24 + extra));
                put_noise(16);
                put32($urandom);
                put32(marked ? TAG_MARK : 32'($urandom));
                put_noise(extra);
                put_pad(extra);
            end
            CK_DATA: begin
                put_header(TAG_DATA, dlen);
                put_noise(dbody);
                put_pad(dbody);
            end
            CK_JUNK: begin
                extra = $urandom_range(0, 11);
                put_header($urandom, 32'(extra));
                put_noise(extra);
                put_pad(extra);
            end
            default: begin
                put_header($urandom, 32'h8000_0000 | 32'($urandom));
                put_noise($urandom_range(0, 20));
            end
        endcase
    endtask

    // Builds a RIFF file in wav_bytes with the chunks asked for, in a random
    // order when shuffle is set.
    task automatic build_file(input bit wave_type, input bit with_fmt,
                              input logic [15:0] fmt_tag, input logic [15:0] bits,
                              input bit with_cue, input bit with_list, input bit marked,
                              input bit with_data, input logic [31:0] dlen, input int dbody,
                              input int junk, input bit with_neg, input bit shuffle);
        chunk_kind_t plan[$];
        chunk_kind_t tmp;
        int j;
        wav_bytes.delete();
        if ($urandom_range(0, 4) == 0)
            put_chunk(CK_JUNK, 16'd0, 16'd0, 1'b0, 32'd0, 0);
        put_header(TAG_RIFF, $urandom_range(0, 32'h7FFF_FFFF));
        put32(wave_type ? TAG_WAVE : 32'($urandom));
        if (with_fmt) plan.push_back(CK_FMT);
        if (with_cue) plan.push_back(CK_CUE);
        if (with_list) plan.push_back(CK_LIST);
        repeat (junk) plan.push_back(CK_JUNK);
        if (with_neg) plan.push_back(CK_NEG);
        if (with_data) plan.push_back(CK_DATA);
        if (shuffle) begin
            for (int i = plan.size() - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = plan[i];
                plan[i] = plan[j];
                plan[j] = tmp;
            end
        end
        foreach (plan[i])
            put_chunk(plan[i], fmt_tag, bits, marked, dlen, dbody);
    endtask

    task automatic build_random_file();
        logic [15:0] bits;
        logic [31:0] dlen;
        int dbody;
        int cut;
        if ($urandom_range(0, 99) < 8) begin
            wav_bytes.delete();
            put_noise($urandom_range(1, 40));
            return;
        end
        case ($urandom_range(0, 5))
            0: bits = 16'd8;
            1: bits = 16'd16;
            2: bits = 16'd24;
            3: bits = 16'd32;
            4: bits = 16'($urandom_range(0, 7));
            default: bits = 16'($urandom);
        endcase
        dbody = $urandom_range(0, 40);
        dlen = ($urandom_range(0, 3) == 0) ? ($urandom & 32'h7FFF_FFFF) : 32'(dbody);
        build_file($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                   ($urandom_range(0, 4) != 0) ? 16'd1 : 16'($urandom),
                   bits, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 3) != 0, $urandom_range(0, 6) != 0, dlen, dbody,
                   $urandom_range(0, 2), $urandom_range(0, 19) == 0,
                   1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, wav_bytes.size());
            while (wav_bytes.size() > cut)
                void'(wav_bytes.pop_back());
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_beat <= '{file_byte: b, last_byte: fin};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_file();
        bytes_sent += wav_bytes.size();
        foreach (wav_bytes[i])
            send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_ignore_cue(input logic value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 2'(REG_IGNORE_CUE * 4);
        pwdata <= {31'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_files();
        // Minimal good file, then each status in turn.
        build_file(1, 1, 16'd1, 16'd16, 0, 0, 0, 1, 32'd8, 8, 0, 0, 0); send_file();
        wav_bytes.delete(); put8(8'hFF); send_file();
        wav_bytes.delete(); put8(8'h00); send_file();
        build_file(0, 1, 16'd1, 16'd16, 0, 0, 0, 1, 32'd4, 4, 0, 0, 0); send_file();
        build_file(1, 0, 16'd1, 16'd16, 0, 0, 0, 1, 32'd4, 4, 0, 0, 0); send_file();
        build_file(1, 1, 16'hFFFF, 16'd16, 1, 0, 0, 1, 32'd4, 4, 0, 0, 0); send_file();
        build_file(1, 1, 16'd1, 16'd16, 1, 1, 1, 0, 32'd0, 0, 0, 0, 0); send_file();
        build_file(1, 1, 16'd1, 16'd7, 1, 1, 1, 1, 32'd6, 6, 0, 0, 0); send_file();
        build_file(1, 1, 16'd1, 16'hFFFF, 1, 1, 0, 1, 32'h7FFF_FFFF, 3, 1, 0, 0);
        send_file();
        // A negative length stops the walk before the data chunk.
        build_file(1, 1, 16'd1, 16'd8, 0, 0, 0, 1, 32'd5, 5, 0, 1, 0);
        send_file();
        // Header cut off inside the first chunk.
        build_file(1, 1, 16'd1, 16'd8, 0, 0, 0, 1, 32'd5, 5, 0, 0, 0);
        while (wav_bytes.size() > 16) void'(wav_bytes.pop_back());
        send_file();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_ignore_cue(1'b0);
        directed_files();
        wait_idle();
        write_ignore_cue(1'b1);
        directed_files();
        wait_idle();
        write_ignore_cue(1'b0);
        while (bytes_sent < 2000) begin
            build_random_file();
            send_file();
            if ($urandom_range(0, 7) == 0) begin
                wait_idle();
                write_ignore_cue(1'($urandom_range(0, 1)));
            end
        end
        wait_idle();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== wav_header_parser_unit.f =====
hdl/wavhp_pkg.sv
hdl/wavhp_datapath.sv
hdl/wavhp_ctrl.sv
hdl/wav_header_parser_unit.sv
test/wavhp_checker.sv
test/testbench.sv
